@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that an expression never holds outside reset
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/spm_pkg.sv @@
// Package: types and constants of the sparse polynomial multiplier
package spm_pkg;
    localparam int MaxTerms = 8;
    localparam int TermIdxW = $clog2(MaxTerms);
    localparam int CountW   = $clog2(MaxTerms + 1);
    localparam int ProdCap  = MaxTerms * MaxTerms;
    localparam int ProdIdxW = $clog2(ProdCap);
    localparam int ProdCntW = $clog2(ProdCap + 1);
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_MUL    = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    // Request passed from the front part to the back part
    typedef struct packed {
        logic              is_mul;
        logic              to_b;
        logic              full;
        logic [31:0]       coeff;
        logic signed [15:0] expo;
    } t_req;
endpackage

@@ hw/rtl/spm_front.sv @@
// Front part: accept requests, classify them and queue them for the back part
module spm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_opcode,
    input  logic signed [31:0] i_term_coeff,
    input  logic signed [15:0] i_term_exponent,
    output logic           o_req_valid,
    input  logic           i_req_take,
    output spm_pkg::t_req  o_req
);
    import spm_pkg::*;

    localparam int QIdxW = $clog2(QueueDepth);

    t_req              r_q [QueueDepth];
    logic [QIdxW-1:0]  r_wr, r_rd;
    logic [QIdxW:0]    r_cnt;
    logic              push, pop;
    t_req              n_req;

    assign o_stall     = (r_cnt == (QIdxW+1)'(QueueDepth));
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rd];

    // Classify: opcode 3 is dropped here and never queued
    assign push = i_valid && !o_stall && (t_opcode'(i_opcode) != OP_NONE);
    assign pop  = o_req_valid && i_req_take;

    always_comb begin
        n_req        = '0;
        n_req.is_mul = (t_opcode'(i_opcode) == OP_MUL);
        n_req.to_b   = (t_opcode'(i_opcode) == OP_LOAD_B);
        n_req.coeff  = i_term_coeff;
        n_req.expo   = i_term_exponent;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_req;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QIdxW+1)'(push) - (QIdxW+1)'(pop);
        end
    end
endmodule

@@ hw/rtl/spm_back.sv @@
// Back part: term stores, pairwise products and merge table, result emission
module spm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_take,
    input  spm_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output logic signed [31:0] o_result_coeff,
    output logic signed [16:0] o_result_exponent,
    output logic           o_is_last,
    output logic           o_is_empty,
    output logic           o_dropped_terms
);
    import spm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SCAN_RD, S_SCAN, S_EMIT_RD, S_EMIT
    } t_state;

    t_state                r_state;
    logic [31:0]           r_a_c [MaxTerms];
    logic signed [15:0]    r_a_e [MaxTerms];
    logic [31:0]           r_b_c [MaxTerms];
    logic signed [15:0]    r_b_e [MaxTerms];
    logic [CountW-1:0]     r_a_cnt, r_b_cnt;
    logic                  r_ovf, r_drop;
    logic [TermIdxW-1:0]   r_i, r_j;
    logic                  r_last_pair;
    logic [31:0]           r_pc;
    logic signed [16:0]    r_pe;
    logic [31:0]           r_tc [ProdCap];
    logic signed [16:0]    r_te [ProdCap];
    logic [ProdCntW-1:0]   r_pcnt, r_k;
    logic [31:0]           r_rd_c;
    logic signed [16:0]    r_rd_e;
    logic                  r_out_v;
    logic [31:0]           r_oc;
    logic signed [16:0]    r_oe;
    logic                  r_ol, r_oem, r_od;
    logic                  out_free, hit;
    logic [TermIdxW-1:0]   a_last, b_last;

    assign out_free   = !r_out_v || !i_stall;
    assign o_req_take = (r_state == S_IDLE) && out_free;
    assign a_last = TermIdxW'(r_a_cnt - 1'b1);
    assign b_last = TermIdxW'(r_b_cnt - 1'b1);
    // Compare against the table entry registered in the previous cycle
    assign hit = (r_k != r_pcnt) && (r_rd_e == r_pe);

    assign o_valid           = r_out_v;
    assign o_result_coeff    = r_oc;
    assign o_result_exponent = r_oe;
    assign o_is_last         = r_ol;
    assign o_is_empty        = r_oem;
    assign o_dropped_terms   = r_od;

    // Store loaded terms
    always_ff @(posedge i_clk) begin
        if (o_req_take && i_req_valid && !i_req.is_mul) begin
            if (!i_req.to_b && r_a_cnt != CountW'(MaxTerms)) begin
                r_a_c[r_a_cnt[TermIdxW-1:0]] <= i_req.coeff;
                r_a_e[r_a_cnt[TermIdxW-1:0]] <= i_req.expo;
            end
            if (i_req.to_b && r_b_cnt != CountW'(MaxTerms)) begin
                r_b_c[r_b_cnt[TermIdxW-1:0]] <= i_req.coeff;
                r_b_e[r_b_cnt[TermIdxW-1:0]] <= i_req.expo;
            end
        end
    end

    // Write merge table: add on a hit, append at the end of the scan; register reads
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            if (hit) begin
                r_tc[r_k[ProdIdxW-1:0]] <= r_rd_c + r_pc;
            end else if (r_k == r_pcnt) begin
                r_tc[r_k[ProdIdxW-1:0]] <= r_pc;
                r_te[r_k[ProdIdxW-1:0]] <= r_pe;
            end
        end
        if (r_state == S_SCAN_RD || r_state == S_EMIT_RD) begin
            r_rd_c <= r_tc[r_k[ProdIdxW-1:0]];
            r_rd_e <= r_te[r_k[ProdIdxW-1:0]];
        end
    end

    // Form one product per pair
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_pc <= 32'(r_a_c[r_i] * r_b_c[r_j]);
            r_pe <= 17'(r_a_e[r_i]) + 17'(r_b_e[r_j]);
            r_last_pair <= (r_i == a_last) && (r_j == b_last);
        end
    end

    // Sequence pairs, scans and emission; hold output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a_cnt <= '0;
            r_b_cnt <= '0;
            r_ovf   <= 1'b0;
            r_out_v <= 1'b0;
            r_i <= '0; r_j <= '0; r_k <= '0; r_pcnt <= '0; r_drop <= 1'b0;
        end else begin
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_req_take && i_req_valid) begin
                        if (!i_req.is_mul) begin
                            if (!i_req.to_b) begin
                                if (r_a_cnt == CountW'(MaxTerms)) r_ovf <= 1'b1;
                                else r_a_cnt <= r_a_cnt + 1'b1;
                            end else begin
                                if (r_b_cnt == CountW'(MaxTerms)) r_ovf <= 1'b1;
                                else r_b_cnt <= r_b_cnt + 1'b1;
                            end
                        end else if (r_a_cnt == '0 || r_b_cnt == '0) begin
                            r_out_v <= 1'b1;
                            r_oc <= '0; r_oe <= '0;
                            r_ol <= 1'b1; r_oem <= 1'b1; r_od <= r_ovf;
                            r_a_cnt <= '0; r_b_cnt <= '0; r_ovf <= 1'b0;
                        end else begin
                            r_drop <= r_ovf;
                            r_i <= '0; r_j <= '0; r_pcnt <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_k <= '0;
                    r_state <= S_SCAN_RD;
                    if (r_j == b_last) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (hit || r_k == r_pcnt) begin
                        if (!hit) r_pcnt <= r_pcnt + 1'b1;
                        if (r_last_pair) begin
                            r_k <= '0;
                            r_state <= S_EMIT_RD;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_v <= 1'b1;
                        r_oc <= r_rd_c; r_oe <= r_rd_e;
                        r_ol <= (r_k + 1'b1 == r_pcnt);
                        r_oem <= 1'b0; r_od <= r_drop;
                        if (r_k + 1'b1 == r_pcnt) begin
                            r_a_cnt <= '0; r_b_cnt <= '0; r_ovf <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/sparse_polynomial_multiplier_unit.sv @@
// Load: one request per cycle through a 2-deep queue while o_stall is low.
// Multiply: each term pair passes S_MUL, then S_SCAN_RD and S_SCAN per merge table
// entry passed over, then S_EMIT_RD and S_EMIT per result term; the single product/merge unit takes one pair at a time.
// Empty operand multiply: the result is written into the output register from S_IDLE.
// Reset (synchronous, active low) empties queue, counts, overflow flag, output.
// Top level: front classifier, request queue and back-end multiplier
module sparse_polynomial_multiplier_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_term_coeff,
    input  logic signed [15:0] i_term_exponent,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_coeff,
    output logic signed [16:0] o_result_exponent,
    output logic               o_is_last,
    output logic               o_is_empty,
    output logic               o_dropped_terms
);
    import spm_pkg::*;
    `include "assert_macros.svh"

    logic req_valid, req_take;
    t_req req;

    spm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_term_coeff,
        .i_term_exponent, .o_req_valid(req_valid), .i_req_take(req_take), .o_req(req)
    );

    spm_back u_back (
        .i_clk, .i_rst_n, .i_req_valid(req_valid), .o_req_take(req_take),
        .i_req(req), .o_valid, .i_stall, .o_result_coeff, .o_result_exponent,
        .o_is_last, .o_is_empty, .o_dropped_terms
    );

    // Empty results carry zero term fields and close the multiply
    `ASSERT_IMP(a_empty_fields, o_valid && o_is_empty, o_is_last && o_result_coeff == '0)
    // A stalled result holds its value
    `ASSERT_IMP(a_hold, $past(o_valid && i_stall) && i_rst_n && $past(i_rst_n), o_valid && $stable(o_result_coeff))
    // No request taken while a stalled result is still waiting on the back side
    `ASSERT_NEVER(a_take_stall, req_take && o_valid && i_stall)
endmodule
